// ===== design/deq_pkg.sv =====
package deq_pkg;

   // Field widths of the request and response transactions
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   // Defaults for the top-level parameters
   localparam int DEF_DEPTH      = 1024;
   localparam int DEF_DATA_WIDTH = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 3'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] OP_READ_AT    = 3'd2;
   localparam logic [FUNC_W-1:0] OP_READ_FRONT = 3'd3;
   localparam logic [FUNC_W-1:0] OP_READ_BACK  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DONE
   } deq_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // perform the operation on the store
   } deq_cmd_type;

endpackage

// ===== design/double_ended_queue_buffer.sv =====
// Bounded double-ended queue in a circular store of DEPTH elements. Issue a
// transaction by raising start while busy is low, with req_func choosing push
// back, push front, read at index, read front or read back. Each transaction
// yields exactly one response after the capture and execute states: rsp_valid
// is high for a single cycle and the receiver cannot stall it, so capture the
// rsp_ ports in that cycle. A new transaction may be issued in the cycle the
// response is shown; none is taken while busy is high in the execute state.
// The store needs no clearing pass after reset: only slots inside the held
// range ever return their data. Pushes into a full queue, out-of-range
// indices and front or back reads on an empty queue leave the queue untouched
// and return zero data with an error status.
module double_ended_queue_buffer
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEF_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_valid,
   output logic [DATA_W-1:0]   rsp_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_is_empty
);

   deq_cmd_type cmd;

   // Sequence capture, execute and response
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Hold the head pointer, the element count and the element store
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_index    (req_index),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   // An accepted transaction is executed in the very next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && cmd.execute))
      else $error("accepted transaction not executed");

   // Execution is always followed by exactly one response strobe
   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_valid && !cmd.execute))
      else $error("execution without response");

   // A response never arrives without an execution just before it
   a_resp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.execute))
      else $error("spurious response");

   // Errors carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_data == '0))
      else $error("error response with non-zero data");

endmodule

// ===== design/deq_ctrl.sv =====
module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output deq_cmd_type cmd
);

   deq_state_type state_ff;
   deq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // present the result and take the next request alongside it
            rsp_valid = 1'b1;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/deq_datapath.sv =====
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEF_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  deq_cmd_type         cmd,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_index,
   output logic [DATA_W-1:0]   rsp_data,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_is_empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

   logic [FUNC_W-1:0]     func_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [INDEX_W-1:0]    index_ff;

   logic [PW-1:0]         head_ff;
   logic [PW-1:0]         head_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;

   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic                  rd_ok_ff;
   logic                  rd_ok_in;
   logic [DATA_WIDTH-1:0] rd_ff;

   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [PW-1:0]         addr;
   logic                  mem_wr;
   logic                  is_full;
   logic                  is_void;

   // physical slot of a logical position, wrapped by one subtraction of DEPTH
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head,
                                             input logic [SW-1:0] logical);
      logic [SW-1:0] sum;
      sum = SW'(head) + logical;
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= DATA_WIDTH'(req_value);
         index_ff <= req_index;
      end
   end

   assign is_full = (count_ff == CW'(DEPTH));
   assign is_void = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      mem_wr    = 1'b0;
      addr      = head_ff;
      case (func_ff)
         OP_PUSH_REAR: begin
            addr = slot_of(head_ff, SW'(count_ff));
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               mem_wr   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            addr = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - 1'b1;
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               mem_wr   = 1'b1;
               head_in  = addr;
               count_in = count_ff + 1'b1;
            end
         end
         OP_READ_AT: begin
            addr = slot_of(head_ff, SW'(index_ff));
            if (SW'(index_ff) >= SW'(count_ff)) begin
               status_in = ST_RANGE;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         OP_READ_FRONT: begin
            if (is_void) begin
               status_in = ST_EMPTY;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         OP_READ_BACK: begin
            addr = slot_of(head_ff, SW'(count_ff - 1'b1));
            if (is_void) begin
               status_in = ST_EMPTY;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            // unused codes: no change, status ok, data zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (mem_wr) begin
            store_mem[addr] <= value_ff;
         end
         rd_ff <= store_mem[addr];
      end
   end

   assign rsp_data     = DATA_W'(rd_ok_ff ? rd_ff : {DATA_WIDTH{1'b0}});
   assign rsp_status   = status_ff;
   assign rsp_count    = COUNT_W'(count_ff);
   assign rsp_is_empty = is_void;

endmodule

// ===== tb/sv/double_ended_queue_buffer_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_buffer_tb
   import deq_pkg::*;
();

   localparam int DEPTH      = DEF_DEPTH;
   localparam int DATA_WIDTH = DEF_DATA_WIDTH;
   localparam int PEND_DEPTH = 16;

   // Operation codes with no defined meaning
   localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [FUNC_W-1:0] OP_SPARE_C = 3'd7;

   // One response transaction as the block reports it
   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
   } deq_rsp_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [FUNC_W-1:0]   req_func;
   logic [VALUE_W-1:0]  req_value;
   logic [INDEX_W-1:0]  req_index;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_is_empty;

   // Shadow copy of the deque: circular store, head slot and element count
   logic [DATA_W-1:0]   shadow_store [DEPTH];
   int unsigned         shadow_head;
   int unsigned         shadow_count;

   // Responses predicted for accepted requests, oldest first
   deq_rsp_type         pending_rsp [PEND_DEPTH];
   int unsigned         pend_wr;
   int unsigned         pend_rd;
   int                  n_errors;
   // Sender gaps are drawn only while this is set; cleared for back-to-back stretches
   bit                  gaps_on;

   double_ended_queue_buffer u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_index    (req_index),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   // 4 ns period: high for 2 ns, low for 2 ns
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one operation to the shadow deque and return the response it must give.
   // Logical index i lives in slot (head + i) mod DEPTH.
   function automatic deq_rsp_type predict_deque_op(logic [FUNC_W-1:0]  op,
                                                    logic [VALUE_W-1:0] value,
                                                    logic [INDEX_W-1:0] index);
      deq_rsp_type rsp;
      rsp        = '0;
      rsp.status = ST_OK;
      case (op)
         OP_PUSH_REAR: begin
            if (shadow_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               shadow_store[(shadow_head + shadow_count) % DEPTH] =
                  DATA_W'(value[DATA_WIDTH-1:0]);
               shadow_count++;
            end
         end
         OP_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               // step the head back one slot, wrapping below slot zero
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_store[shadow_head] = DATA_W'(value[DATA_WIDTH-1:0]);
               shadow_count++;
            end
         end
         OP_READ_AT: begin
            if (index >= shadow_count) rsp.status = ST_RANGE;
            else rsp.data = shadow_store[(shadow_head + index) % DEPTH];
         end
         OP_READ_FRONT: begin
            if (shadow_count == 0) rsp.status = ST_EMPTY;
            else rsp.data = shadow_store[shadow_head];
         end
         OP_READ_BACK: begin
            if (shadow_count == 0) rsp.status = ST_EMPTY;
            else rsp.data = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
         end
         default: ;   // unused codes leave everything as it was
      endcase
      rsp.count    = shadow_count[COUNT_W-1:0];
      rsp.is_empty = (shadow_count == 0);
      return rsp;
   endfunction

   // Issue one request transaction: idle for the drawn gap, raise start with the
   // fields, hold until an edge sees busy low, then log the predicted response.
   // start stays high straight into the next transaction when the gap is zero.
   task automatic send_op(logic [FUNC_W-1:0]  op,
                          logic [VALUE_W-1:0] value,
                          logic [INDEX_W-1:0] index);
      int gap;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start     <= 1'b0;
         // scramble the idle payload so only the start-qualified one counts
         req_func  <= FUNC_W'($urandom);
         req_value <= $urandom;
         req_index <= INDEX_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_func  <= op;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
      pending_rsp[pend_wr % PEND_DEPTH] = predict_deque_op(op, value, index);
      pend_wr++;
   endtask

   // Values lean on the all-zeros and all-ones patterns now and then
   function automatic logic [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly in-range indices, with out-of-range and fully random ones mixed in
   function automatic logic [INDEX_W-1:0] draw_index();
      int roll;
      roll = $urandom_range(0, 9);
      if (shadow_count == 0 || roll < 2)
         return INDEX_W'($urandom_range(0, DEPTH - 1));
      if (roll < 4 && shadow_count < DEPTH)
         return INDEX_W'($urandom_range(shadow_count, DEPTH - 1));
      return INDEX_W'($urandom_range(0, shadow_count - 1));
   endfunction

   task automatic send_push(logic [VALUE_W-1:0] value);
      send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR, value, draw_index());
   endtask

   // Reads and unused codes on a freshly reset, empty queue
   task automatic test_empty_queue();
      gaps_on = 1'b0;
      send_op(OP_READ_FRONT, 32'hFFFF_FFFF, '0);
      send_op(OP_READ_BACK,  32'hFFFF_FFFF, '1);
      send_op(OP_READ_AT,    '0,            '0);
      send_op(OP_READ_AT,    '1,            '1);
      send_op(OP_SPARE_A, 32'h1234_5678, 10'd3);
      send_op(OP_SPARE_B, '1, '1);
      send_op(OP_SPARE_C, '0, '0);
   endtask

   // First push goes to the front, so the head wraps below slot zero
   task automatic test_head_wrap();
      gaps_on = 1'b1;
      send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, '0);
      send_op(OP_READ_FRONT, '0, '0);
      send_op(OP_READ_BACK,  '0, '0);
      send_op(OP_READ_AT,    '0, 10'd0);
      send_op(OP_READ_AT,    '0, 10'd1);
      send_op(OP_PUSH_REAR,  32'h0000_0000, '1);
      send_op(OP_READ_BACK,  '0, '0);
      send_op(OP_READ_AT,    '0, 10'd1);
      send_op(OP_PUSH_FRONT, 32'hA5A5_5A5A, '0);
      send_op(OP_READ_AT,    '0, 10'd2);
      send_op(OP_READ_AT,    '0, 10'd3);
      send_op(OP_READ_FRONT, '0, '0);
      send_op(OP_SPARE_A,    '1, 10'd0);
      send_op(OP_READ_AT,    '0, '1);
   endtask

   // Random mix of pushes and reads; unused codes are sprinkled in but not counted
   task automatic test_random_mix(int n_items);
      int done;
      int roll;
      done = 0;
      while (done < n_items) begin
         if (done % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 40)      send_push(draw_value());
         else if (roll < 80) send_op(OP_READ_AT, draw_value(), draw_index());
         else if (roll < 88) send_op(OP_READ_FRONT, draw_value(), draw_index());
         else if (roll < 96) send_op(OP_READ_BACK, draw_value(), draw_index());
         else begin
            send_op(FUNC_W'($urandom_range(OP_SPARE_A, OP_SPARE_C)), draw_value(),
                    draw_index());
            continue;
         end
         done++;
      end
   endtask

   // Push until the store is full, reading back now and then on the way
   task automatic test_fill_to_full();
      int n;
      n = 0;
      while (shadow_count < DEPTH) begin
         if (n % 64 == 0) gaps_on = ($urandom_range(0, 1) != 0);
         if ($urandom_range(0, 7) == 0) send_op(OP_READ_AT, '0, draw_index());
         else send_push(draw_value());
         n++;
      end
   endtask

   // Refused pushes, then reads across the whole full store
   task automatic test_full_queue();
      gaps_on = 1'b1;
      send_op(OP_PUSH_REAR,  '1, '0);
      send_op(OP_PUSH_FRONT, '0, '1);
      send_op(OP_READ_FRONT, '0, '0);
      send_op(OP_READ_BACK,  '0, '0);
      send_op(OP_READ_AT,    '0, 10'd0);
      send_op(OP_READ_AT,    '0, '1);
      send_op(OP_SPARE_B,    '1, '1);
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_push(draw_value());
         else send_op(OP_READ_AT, draw_value(), draw_index());
      end
   endtask

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      n_errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endtask

   // Response checker: the block cannot be stalled, so take every strobed
   // transaction at the edge that ends its cycle and match it to the oldest prediction.
   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pend_wr == pend_rd) begin
            n_errors++;
            $display("%0t: unexpected response: expected none, actual data 0x%0h status %0d",
                     $time, rsp_data, rsp_status);
         end else begin
            want = pending_rsp[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_data !== want.data)
               report_mismatch("data", 32'(want.data), 32'(rsp_data));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_count !== want.count)
               report_mismatch("count", 32'(want.count), 32'(rsp_count));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
         end
      end
   end

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_func     = OP_PUSH_REAR;
      req_value    = '0;
      req_index    = '0;
      n_errors     = 0;
      gaps_on      = 1'b0;
      shadow_head  = 0;
      shadow_count = 0;
      pend_wr      = 0;
      pend_rd      = 0;
      // hold reset, then release it away from the rising edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_head_wrap();
      test_random_mix(200);
      test_fill_to_full();
      test_full_queue();

      @(negedge clock);
      start <= 1'b0;
      // drain outstanding responses, then keep watching for stray strobes
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (10) @(posedge clock);

      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is well under 100 us
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
